FILE: hdl/lfu_pkg.sv
// Shared types and constants for the LFU key-value store.
package lfu_pkg;

	localparam int MAX_ENTRIES  = 16;
	localparam int COUNT_BITS   = 16;
	localparam int KEY_BITS     = 32;
	localparam int DATA_BITS    = 32;
	localparam int CAP_BITS     = 5;
	localparam int IDX_BITS     = $clog2(MAX_ENTRIES);
	localparam int FILL_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_BITS     = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;
	localparam int S_TDATA_BITS = KEY_BITS + DATA_BITS;
	localparam int M_FIELD_BITS = 1 + DATA_BITS + 1 + KEY_BITS;
	localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;
	localparam int M_PAD_BITS   = M_TDATA_BITS - M_FIELD_BITS;

	localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [IDX_BITS-1:0]   rank_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FILL_BITS-1:0]  fill_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] value;
		count_t               count;
	} entry_t;

	// touch: make idx most recent (ref_rank is its current rank)
	// add:   mark idx valid as the newest entry, age all others
	typedef struct packed {
		logic  touch;
		logic  add;
		idx_t  idx;
		rank_t ref_rank;
	} rank_op_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

endpackage

FILE: hdl/lfu_rank.sv
// Per-entry valid bits, recency ranks and fill count.
module lfu_rank (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfu_pkg::rank_op_t                  op,
	input  lfu_pkg::idx_t                      rd_idx,
	output logic [lfu_pkg::MAX_ENTRIES-1:0]    valid,
	output lfu_pkg::rank_t                     rank_rd,
	output lfu_pkg::fill_t                     fill,
	output lfu_pkg::idx_t                      first_free
);

	logic [lfu_pkg::MAX_ENTRIES-1:0] valid_q;
	lfu_pkg::rank_t                  rank_q [lfu_pkg::MAX_ENTRIES];
	lfu_pkg::fill_t                  fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (op.add) begin
			valid_q[op.idx] <= 1'b1;
			fill_q          <= fill_q + lfu_pkg::fill_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
			if (op.touch) begin
				if (lfu_pkg::idx_t'(i) == op.idx)
					rank_q[i] <= '0;
				else if (valid_q[i] && rank_q[i] < op.ref_rank)
					rank_q[i] <= rank_q[i] + lfu_pkg::rank_t'(1);
			end else if (op.add) begin
				if (lfu_pkg::idx_t'(i) == op.idx)
					rank_q[i] <= '0;
				else if (valid_q[i])
					rank_q[i] <= rank_q[i] + lfu_pkg::rank_t'(1);
			end
		end
	end

	always_comb begin
		first_free = '0;
		for (int i = lfu_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i])
				first_free = lfu_pkg::idx_t'(i);
		end
	end

	assign valid   = valid_q;
	assign rank_rd = rank_q[rd_idx];
	assign fill    = fill_q;

endmodule

FILE: hdl/lfu_cache_replacement.sv
// Top level: LFU key-value store with LRU tie-break, memory scan per item.
//
//  channel | dir | fields (low bit first)
//  s_*     | in  | tdata: lookup_key[31:0], write_value[63:32]; tuser: cmd
//  m_*     | out | tdata: hit, read_value, evicted, evicted_key, zero pad
//  cfg_*   | in  | capacity, written when cfg_wen is high
//
// Each item goes through accept, 16 reads of the entry memory (one per entry),
// a drain state for the last read's data, and a commit state with the write-back.
// Reset clears the valid bits and sets capacity to 16; no clearing pass.
// A result waiting on m_tready holds the commit; the next item is taken as
// soon as the previous one has committed into the output register.
module lfu_cache_replacement (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lfu_pkg::S_TDATA_BITS-1:0] s_tdata,   // lookup_key, write_value
	input  logic                             s_tuser,   // cmd
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lfu_pkg::M_TDATA_BITS-1:0] m_tdata,   // hit, read_value, evicted, evicted_key
	input  logic                             cfg_wen,
	input  logic [lfu_pkg::CAP_BITS-1:0]     cfg_wdata
);

	lfu_pkg::state_t                  state_q;
	lfu_pkg::idx_t                    addr_q;
	logic                             cmd_q;
	logic [lfu_pkg::KEY_BITS-1:0]     key_q;
	logic [lfu_pkg::DATA_BITS-1:0]    val_q;
	logic [lfu_pkg::CAP_BITS-1:0]     capacity_q;

	lfu_pkg::entry_t                  mem [lfu_pkg::MAX_ENTRIES];
	lfu_pkg::entry_t                  rd_data_s1;
	logic                             rd_vld_s1;
	lfu_pkg::idx_t                    rd_idx_s1;

	logic                             match_q;
	lfu_pkg::idx_t                    match_idx_q;
	logic [lfu_pkg::DATA_BITS-1:0]    match_val_q;
	lfu_pkg::count_t                  match_cnt_q;
	lfu_pkg::rank_t                   match_rank_q;
	logic                             vic_q;
	lfu_pkg::idx_t                    vic_idx_q;
	lfu_pkg::count_t                  vic_cnt_q;
	lfu_pkg::rank_t                   vic_rank_q;
	logic [lfu_pkg::KEY_BITS-1:0]     vic_key_q;

	logic                             m_valid_q;
	logic [lfu_pkg::M_TDATA_BITS-1:0] m_data_q;

	logic [lfu_pkg::MAX_ENTRIES-1:0]  valid;
	lfu_pkg::rank_t                   rank_rd;
	lfu_pkg::fill_t                   fill;
	lfu_pkg::idx_t                    first_free;
	lfu_pkg::rank_op_t                op;

	logic                             accept;
	logic                             go;
	logic                             cur_valid;
	logic                             cur_match;
	logic                             cur_better;
	logic [lfu_pkg::CMP_BITS-1:0]     cap_eff;
	logic [lfu_pkg::CMP_BITS-1:0]     fill_ext;
	lfu_pkg::count_t                  cnt_inc;
	logic                             mem_we;
	lfu_pkg::idx_t                    mem_waddr;
	lfu_pkg::entry_t                  mem_wdata;
	logic [lfu_pkg::DATA_BITS-1:0]    res_rd;
	logic                             res_ev;
	logic [lfu_pkg::KEY_BITS-1:0]     res_evk;

	lfu_rank u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.rd_idx     (rd_idx_s1),
		.valid      (valid),
		.rank_rd    (rank_rd),
		.fill       (fill),
		.first_free (first_free)
	);

	assign s_tready = (state_q == lfu_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign go       = (state_q == lfu_pkg::ST_COMMIT) && (!m_valid_q || m_tready);

	assign cur_valid  = rd_vld_s1 && valid[rd_idx_s1];
	assign cur_match  = cur_valid && !match_q && (rd_data_s1.key == key_q);
	assign cur_better = cur_valid && (!vic_q || rd_data_s1.count < vic_cnt_q ||
		(rd_data_s1.count == vic_cnt_q && rank_rd > vic_rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= lfu_pkg::CAP_RESET;
		else if (cfg_wen)
			capacity_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lfu_pkg::ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == lfu_pkg::ST_SCAN);
			unique case (state_q)
				lfu_pkg::ST_IDLE: begin
					if (accept)
						state_q <= lfu_pkg::ST_SCAN;
				end
				lfu_pkg::ST_SCAN: begin
					if (addr_q == lfu_pkg::idx_t'(lfu_pkg::MAX_ENTRIES - 1))
						state_q <= lfu_pkg::ST_DRAIN;
				end
				lfu_pkg::ST_DRAIN: begin
					state_q <= lfu_pkg::ST_COMMIT;
				end
				lfu_pkg::ST_COMMIT: begin
					if (go)
						state_q <= lfu_pkg::ST_IDLE;
				end
				default: state_q <= lfu_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (accept) begin
			addr_q <= '0;
			cmd_q  <= s_tuser;
			key_q  <= s_tdata[lfu_pkg::KEY_BITS-1:0];
			val_q  <= s_tdata[lfu_pkg::S_TDATA_BITS-1:lfu_pkg::KEY_BITS];
		end else if (state_q == lfu_pkg::ST_SCAN) begin
			addr_q <= addr_q + lfu_pkg::idx_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			vic_q   <= 1'b0;
		end else if (accept) begin
			match_q <= 1'b0;
			vic_q   <= 1'b0;
		end else begin
			if (cur_match)
				match_q <= 1'b1;
			if (cur_better)
				vic_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cur_match) begin
			match_idx_q  <= rd_idx_s1;
			match_val_q  <= rd_data_s1.value;
			match_cnt_q  <= rd_data_s1.count;
			match_rank_q <= rank_rd;
		end
		if (cur_better) begin
			vic_idx_q  <= rd_idx_s1;
			vic_cnt_q  <= rd_data_s1.count;
			vic_rank_q <= rank_rd;
			vic_key_q  <= rd_data_s1.key;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_s1 <= mem[addr_q];
	end

	always_comb begin
		if (lfu_pkg::CMP_BITS'(capacity_q) > lfu_pkg::CMP_BITS'(lfu_pkg::MAX_ENTRIES))
			cap_eff = lfu_pkg::CMP_BITS'(lfu_pkg::MAX_ENTRIES);
		else
			cap_eff = lfu_pkg::CMP_BITS'(capacity_q);
		fill_ext = lfu_pkg::CMP_BITS'(fill);
		cnt_inc  = (match_cnt_q == lfu_pkg::COUNT_MAX) ? match_cnt_q :
			match_cnt_q + lfu_pkg::count_t'(1);

		mem_we    = 1'b0;
		mem_waddr = match_idx_q;
		mem_wdata = '{key: key_q, value: val_q, count: lfu_pkg::count_t'(1)};
		op        = '0;
		res_rd    = '1;
		res_ev    = 1'b0;
		res_evk   = '0;

		// a put to a present key changes nothing at zero capacity
		if (match_q && (cmd_q == lfu_pkg::CMD_GET || cap_eff != '0)) begin
			mem_we      = go;
			op.touch    = go;
			op.idx      = match_idx_q;
			op.ref_rank = match_rank_q;
			if (cmd_q == lfu_pkg::CMD_GET) begin
				res_rd    = match_val_q;
				mem_wdata = '{key: key_q, value: match_val_q, count: cnt_inc};
			end else begin
				mem_wdata = '{key: key_q, value: val_q, count: cnt_inc};
			end
		end else if (!match_q && cmd_q == lfu_pkg::CMD_PUT && cap_eff != '0) begin
			mem_we = go;
			if (fill_ext >= cap_eff) begin
				res_ev      = 1'b1;
				res_evk     = vic_key_q;
				mem_waddr   = vic_idx_q;
				op.touch    = go;
				op.idx      = vic_idx_q;
				op.ref_rank = vic_rank_q;
			end else begin
				mem_waddr = first_free;
				op.add    = go;
				op.idx    = first_free;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (go)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go)
			m_data_q <= {{lfu_pkg::M_PAD_BITS{1'b0}}, res_evk, res_ev, res_rd, match_q};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

FILE: hdl/lfu_checker.sv
// Port-level assertions for the LFU store, bound to the top level.
module lfu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lfu_pkg::M_TDATA_BITS-1:0] m_tdata
);

	localparam int RD_LO  = 1;
	localparam int EV_BIT = 1 + lfu_pkg::DATA_BITS;
	localparam int EVK_LO = EV_BIT + 1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transfer taken while an item is in work");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[EV_BIT] |->
		!m_tdata[0] && m_tdata[EV_BIT-1:RD_LO] == '1)
		else $error("eviction reported on a hit or with a read value");

	a_evk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[EV_BIT] |->
		m_tdata[EVK_LO+lfu_pkg::KEY_BITS-1:EVK_LO] == '0)
		else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
